// ===== hw/rtl/psu_pkg.sv =====
package psu_pkg;

  // geometry limits
  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_ROW_BYTES = 16384;

  // field and counter widths
  localparam int BYTE_W     = 8;
  localparam int WIDTH_W    = 13;
  localparam int BPP_W      = 3;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = $clog2(MAX_ROW_BYTES);
  localparam int COL_W      = POS_W + 1;
  localparam int ROW_W      = HEIGHT_W;
  localparam int K_W        = 2;
  localparam int MAX_BPP    = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_BPP    = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // row filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // one sample or bad-filter request handed to the reconstruction stage
  typedef struct packed {
    logic              bad;
    logic [BYTE_W-1:0] x;
    logic [POS_W-1:0]  pos;
    logic [K_W-1:0]    k;
    filt_t             filt;
    logic              a_en;
    logic              b_en;
    logic              rlast;
    logic              ilast;
    logic              emit;
  } req_t;

  // control from the counter block to the reconstruction stage
  typedef struct packed {
    logic push;
    logic hist_clr;
    req_t req;
  } psu_ctl_t;

  // one result
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_last;
    logic              image_last;
    logic              bad_filter;
  } res_t;

endpackage

// ===== hw/rtl/psu_ifs.sv =====
interface psu_in_if;
  import psu_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface psu_out_if;
  import psu_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              row_last;
  logic              image_last;
  logic              bad_filter;

  modport source (output valid, output pixel_byte, output row_last, output image_last,
                  output bad_filter, input ready);
  modport sink (input valid, input pixel_byte, input row_last, input image_last,
                input bad_filter, output ready);
endinterface

// ===== hw/rtl/psu_ctrl.sv =====
module psu_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic [psu_pkg::BYTE_W-1:0]       in_byte,
  output logic                             in_ready,
  input  logic                             stage_free,
  output psu_pkg::psu_ctl_t                ctl
);
  import psu_pkg::*;

  // position modulo three, summing base-four digits
  function automatic logic [K_W-1:0] mod3(input logic [POS_W-1:0] p);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < POS_W / 2; i++) begin
      s = s + 5'(p[2*i +: 2]);
    end
    t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
    u = 3'(t[2]) + 3'(t[1:0]);
    mod3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [BPP_W-1:0]    bpp_r, bpp_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  filt_t               filt_r, filt_nxt;
  logic                err_r, err_nxt;

  logic [WIDTH_W-1:0]       eff_w;
  logic [BPP_W-1:0]         eff_bpp;
  logic [HEIGHT_W-1:0]      eff_h;
  logic [WIDTH_W+BPP_W-1:0] row_prod;
  logic [COL_W-1:0]         row_bytes;
  logic [COL_W-1:0]         pos_full;
  logic [POS_W-1:0]         pos;
  logic [K_W-1:0]           k;
  logic                     is_filt;
  logic                     accept;
  logic                     rlast;
  logic                     ilast;
  logic                     bad_code;

  // effective geometry
  always_comb begin
    if (bpp_r == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_BPP)) begin
      eff_bpp = BPP_W'(MAX_BPP);
    end else begin
      eff_bpp = bpp_r;
    end
    if (width_r == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    eff_h    = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    row_prod = (WIDTH_W + BPP_W)'(eff_w) * (WIDTH_W + BPP_W)'(eff_bpp);
    if (row_prod > (WIDTH_W + BPP_W)'(MAX_ROW_BYTES)) begin
      row_bytes = COL_W'(MAX_ROW_BYTES);
    end else begin
      row_bytes = COL_W'(row_prod);
    end
  end

  // byte position, interleave slot and row/image end
  always_comb begin
    pos_full = col_r - COL_W'(1);
    if (col_r > COL_W'(MAX_ROW_BYTES)) begin
      pos = POS_W'(MAX_ROW_BYTES - 1);
    end else begin
      pos = pos_full[POS_W-1:0];
    end
    case (eff_bpp)
      BPP_W'(1): k = '0;
      BPP_W'(2): k = {1'b0, pos[0]};
      BPP_W'(3): k = mod3(pos);
      default:   k = pos[K_W-1:0];
    endcase
    is_filt  = (col_r == '0);
    rlast    = (col_r >= row_bytes);
    ilast    = rlast && (({1'b0, row_r} + (ROW_W + 1)'(1)) >= {1'b0, eff_h});
    bad_code = (in_byte > BYTE_W'(FILT_PAETH));
  end

  assign in_ready = stage_free;
  assign accept   = in_valid && stage_free;

  // request to the reconstruction stage
  always_comb begin
    ctl.push         = accept && (is_filt ? (!err_r && bad_code) : 1'b1);
    ctl.hist_clr     = accept && is_filt;
    ctl.req.bad      = is_filt;
    ctl.req.x        = in_byte;
    ctl.req.pos      = pos;
    ctl.req.k        = k;
    ctl.req.filt     = filt_r;
    ctl.req.a_en     = (pos >= POS_W'(eff_bpp));
    ctl.req.b_en     = (row_r != '0);
    ctl.req.rlast    = !is_filt && rlast;
    ctl.req.ilast    = !is_filt && ilast;
    ctl.req.emit     = is_filt || !err_r;
  end

  // configuration writes
  always_comb begin
    width_nxt  = width_r;
    bpp_nxt    = bpp_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_WIDTH:  width_nxt  = cfg_data[WIDTH_W-1:0];
        CFG_BPP:    bpp_nxt    = cfg_data[BPP_W-1:0];
        CFG_HEIGHT: height_nxt = cfg_data[HEIGHT_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  // column, row, filter and error counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    filt_nxt = filt_r;
    err_nxt  = err_r;
    if (accept) begin
      if (is_filt) begin
        col_nxt = COL_W'(1);
        if (!err_r) begin
          if (bad_code) begin
            err_nxt = 1'b1;
          end else begin
            filt_nxt = filt_t'(in_byte[2:0]);
          end
        end
      end else if (rlast) begin
        col_nxt = '0;
        if (ilast) begin
          row_nxt = '0;
          err_nxt = 1'b0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1);
      bpp_r    <= BPP_W'(1);
      height_r <= HEIGHT_W'(1);
      col_r    <= '0;
      row_r    <= '0;
      filt_r   <= FILT_NONE;
      err_r    <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      bpp_r    <= bpp_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      filt_r   <= filt_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== hw/rtl/psu_recon.sv =====
module psu_recon (
  input  logic               clk,
  input  logic               rst_n,
  input  psu_pkg::psu_ctl_t  ctl,
  output logic               stage_free,
  input  logic               res_free,
  output logic               res_push,
  output psu_pkg::res_t      res
);
  import psu_pkg::*;

  // paeth predictor
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+1:0] da;
    logic signed [BYTE_W+1:0] db;
    logic signed [BYTE_W+1:0] dc;
    logic [BYTE_W+1:0]        pa;
    logic [BYTE_W+1:0]        pb;
    logic [BYTE_W+1:0]        pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

  logic [BYTE_W-1:0] row_mem [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] mem_q_r;
  req_t              req_r;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] left_r [MAX_BPP];
  logic [BYTE_W-1:0] left_nxt [MAX_BPP];
  logic [BYTE_W-1:0] upl_r [MAX_BPP];
  logic [BYTE_W-1:0] upl_nxt [MAX_BPP];

  logic              move;
  logic              wr_en;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W:0]   ab_sum;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] v;

  // stage handshake
  assign move       = valid_r && (!req_r.emit || res_free);
  assign stage_free = !valid_r || move;
  assign res_push   = move && req_r.emit;
  assign wr_en      = move && !req_r.bad;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.push) begin
      valid_nxt = 1'b1;
    end else if (move) begin
      valid_nxt = 1'b0;
    end
  end

  // request register and prior row read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      req_r <= ctl.req;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.req.bad) begin
      mem_q_r <= row_mem[ctl.req.pos];
    end
  end

  // prior row write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[req_r.pos] <= v;
    end
  end

  // neighbors and prediction
  always_comb begin
    a      = req_r.a_en ? left_r[req_r.k] : '0;
    b      = req_r.b_en ? mem_q_r : '0;
    c      = (req_r.a_en && req_r.b_en) ? upl_r[req_r.k] : '0;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (req_r.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = '0;
    endcase
    v = req_r.x + pred;
  end

  // result fields
  always_comb begin
    if (req_r.bad) begin
      res.pixel_byte = '0;
      res.row_last   = 1'b0;
      res.image_last = 1'b0;
      res.bad_filter = 1'b1;
    end else begin
      res.pixel_byte = v;
      res.row_last   = req_r.rlast;
      res.image_last = req_r.ilast;
      res.bad_filter = 1'b0;
    end
  end

  // left and upper-left history, cleared at each filter byte
  always_comb begin
    left_nxt = left_r;
    upl_nxt  = upl_r;
    if (wr_en) begin
      left_nxt[req_r.k] = v;
      upl_nxt[req_r.k]  = b;
    end
    if (ctl.hist_clr) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        left_nxt[i] = '0;
        upl_nxt[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_r[i] <= '0;
        upl_r[i]  <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      left_r  <= left_nxt;
      upl_r   <= upl_nxt;
    end
  end

  // no new request lands on an occupied stage
  assert property (@(posedge clk) disable iff (!rst_n) ctl.push |-> stage_free)
    else $error("request pushed into a busy stage");

  // a bad-filter request never carries row or image end
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && req_r.bad) |-> (!req_r.rlast && !req_r.ilast))
    else $error("bad filter result marked as row end");

  // image end only on a row end
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && req_r.ilast) |-> req_r.rlast)
    else $error("image end without row end");

  // within the first pixel the slot equals the byte position
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && !req_r.bad && !req_r.a_en) |-> (req_r.pos == POS_W'(req_r.k)))
    else $error("interleave slot does not match first pixel position");

endmodule

// ===== hw/rtl/psu_out_buf.sv =====
module psu_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psu_pkg::res_t  din,
  output logic           free,
  psu_out_if.source      out_chan
);
  import psu_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // result register, refilled in the cycle it is taken
  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.pixel_byte = res_r.pixel_byte;
  assign out_chan.row_last   = res_r.row_last;
  assign out_chan.image_last = res_r.image_last;
  assign out_chan.bad_filter = res_r.bad_filter;

endmodule

// ===== hw/rtl/png_scanline_unfilter.sv =====
// PNG scanline unfilter: takes one decompressed byte per cycle while the output
// is not stalled (filter type bytes included) and returns reconstructed sample
// bytes with row and image end flags. A byte is registered in the reconstruction
// stage and its result then in the result register; the block sustains one input
// byte per clock when the output does not stall, limited by the single read and
// single write per cycle of the 16384 x 8 prior-row memory. A filter type byte is
// consumed from the input and yields no result unless it is invalid (above 4),
// which gives one bad_filter result and swallows the rest of that image. The
// prior-row memory needs no clearing pass: the first row of each image ignores
// what it reads. Write the geometry registers only while no bytes are in flight.
module png_scanline_unfilter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
  psu_in_if.sink                         in_chan,
  psu_out_if.source                      out_chan
);
  import psu_pkg::*;

  psu_ctl_t ctl;
  res_t     res;
  logic     stage_free;
  logic     res_free;
  logic     res_push;

  // counters, geometry and filter type decode
  psu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_valid   (in_chan.valid),
    .in_byte    (in_chan.raw_byte),
    .in_ready   (in_chan.ready),
    .stage_free (stage_free),
    .ctl        (ctl)
  );

  // reconstruction stage with prior row memory
  psu_recon u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stage_free (stage_free),
    .res_free   (res_free),
    .res_push   (res_push),
    .res        (res)
  );

  // result register
  psu_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .din      (res),
    .free     (res_free),
    .out_chan (out_chan)
  );

endmodule
